@@ design/mf2d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_pkg
// Shared sizes, types and register codes of the 2-D median filter.
// ----------------------------------------------------------------------------
package mf2d_pkg;

    localparam int MAX_HALF   = 2;
    localparam int MAX_WIDTH  = 4096;
    localparam int PIXEL_BITS = 16;
    localparam int MAX_HEIGHT = 4096;

    localparam int SIDE_MAX = 2 * MAX_HALF + 1;
    localparam int LINES    = 2 * MAX_HALF;
    localparam int WIN_N    = SIDE_MAX * SIDE_MAX;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int POS_W    = 12;
    localparam int HALF_W   = 2;
    localparam int DIM_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int LS_W     = LINES * PIXEL_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        t_REG_HALF   = 2'd0,
        t_REG_WIDTH  = 2'd1,
        t_REG_HEIGHT = 2'd2,
        t_REG_NONE   = 2'd3
    } t_reg_idx;

    typedef logic [PIXEL_BITS-1:0] t_pix;
    typedef t_pix t_win [SIDE_MAX][SIDE_MAX];

    // Position tag carried beside a column through the pipeline.
    typedef struct packed {
        logic             emit;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } t_tag;

endpackage

@@ design/mf2d_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_if
// Valid/ready channel interfaces for pixels, results and configuration.
// ----------------------------------------------------------------------------
interface mf2d_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface mf2d_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] median;
    logic [11:0] out_col;
    logic [11:0] out_row;
    logic        last_of_frame;
    modport source (output valid, output median, output out_col, output out_row,
                    output last_of_frame, input ready);
    modport sink   (input valid, input median, input out_col, input out_row,
                    input last_of_frame, output ready);
endinterface

interface mf2d_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/mf2d_sort.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_sort
// Pipelined median select: odd-even transposition sort, one pass per stage.
// Unused window cells are padded half with zeros, half with all-ones.
// ----------------------------------------------------------------------------
module mf2d_sort (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_valid,
    input  mf2d_pkg::t_tag           i_tag,
    input  logic [mf2d_pkg::HALF_W-1:0] i_half,
    input  mf2d_pkg::t_win           i_win,
    output logic                     o_valid,
    output mf2d_pkg::t_tag           o_tag,
    output logic [mf2d_pkg::PIXEL_BITS-1:0] o_median
);
    localparam int N = mf2d_pkg::WIN_N;
    localparam int S = mf2d_pkg::SIDE_MAX;

    mf2d_pkg::t_pix r_v [N+1][N];
    logic           r_vld [N+1];
    mf2d_pkg::t_tag r_tag [N+1];
    mf2d_pkg::t_pix n_v0 [N];
    mf2d_pkg::t_pix n_vs [N][N];

    // Load stage: pick active cells, pad the rest
    always_comb begin
        int m;
        int side;
        int pad;
        m = 0;
        side = 2 * int'(i_half) + 1;
        pad = (N - side * side) / 2;
        for (int k = 0; k < N; k++) n_v0[k] = '0;
        for (int c = 0; c < S; c++) begin
            for (int r = 0; r < S; r++) begin
                if (c >= S - side && r >= S - side) begin
                    n_v0[pad + m] = i_win[c][r];
                    m = m + 1;
                end
            end
        end
        for (int k = 0; k < N; k++) begin
            if (k >= pad + side * side) n_v0[k] = '1;
        end
    end

    // One compare-exchange pass per stage
    always_comb begin
        for (int s = 1; s <= N; s++) begin
            for (int k = 0; k < N; k++) n_vs[s-1][k] = r_v[s-1][k];
            for (int k = (s % 2); k + 1 < N; k += 2) begin
                if (r_v[s-1][k] > r_v[s-1][k+1]) begin
                    n_vs[s-1][k]   = r_v[s-1][k+1];
                    n_vs[s-1][k+1] = r_v[s-1][k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= N; s++) r_vld[s] <= 1'b0;
        end else if (i_adv) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s <= N; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_v[0]   <= n_v0;
            r_tag[0] <= i_tag;
            for (int s = 1; s <= N; s++) begin
                r_tag[s] <= r_tag[s-1];
                r_v[s]   <= n_vs[s-1];
            end
        end
    end

    assign o_valid  = r_vld[N];
    assign o_tag    = r_tag[N];
    assign o_median = r_v[N][N/2];
endmodule

@@ design/mf2d_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_window
// Line store memory (one word holds all stored rows of a column), column
// read-modify-write and the window shift registers.
// ----------------------------------------------------------------------------
module mf2d_window (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_valid,
    input  logic [mf2d_pkg::COL_W-1:0]     i_col,
    input  logic [mf2d_pkg::PIXEL_BITS-1:0] i_pixel,
    input  mf2d_pkg::t_tag                 i_tag,
    output logic                           o_valid,
    output mf2d_pkg::t_tag                 o_tag,
    output mf2d_pkg::t_win                 o_win
);
    localparam int PB = mf2d_pkg::PIXEL_BITS;
    localparam int L  = mf2d_pkg::LINES;
    localparam int S  = mf2d_pkg::SIDE_MAX;

    logic [mf2d_pkg::LS_W-1:0] mem [mf2d_pkg::MAX_WIDTH];
    logic [mf2d_pkg::LS_W-1:0] r_rdata;
    logic [mf2d_pkg::LS_W-1:0] r_wdata;
    logic [mf2d_pkg::LS_W-1:0] n_wdata;
    logic [mf2d_pkg::LS_W-1:0] rd_col;
    logic [mf2d_pkg::COL_W-1:0] r_col;
    logic [mf2d_pkg::COL_W-1:0] r_wcol;
    logic                      r_wen;
    logic [PB-1:0]             r_pix;
    logic                      r_vld;
    mf2d_pkg::t_tag            r_tag;
    mf2d_pkg::t_win            r_win;

    // Read stage
    always_ff @(posedge i_clk) begin
        if (i_adv) r_rdata <= mem[i_col];
        if (i_adv) begin
            r_col <= i_col;
            r_pix <= i_pixel;
            r_tag <= i_tag;
        end
    end

    // Forward the write made on the read edge when the same column comes back
    assign rd_col  = (r_wen && r_wcol == r_col) ? r_wdata : r_rdata;
    assign n_wdata = {r_pix, rd_col[mf2d_pkg::LS_W-1:PB]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_wen <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_valid;
            r_wen <= r_vld;
        end
    end

    // Write back the shifted column and keep a copy for forwarding
    always_ff @(posedge i_clk) begin
        if (i_adv && r_vld) begin
            mem[r_col] <= n_wdata;
            r_wdata    <= n_wdata;
            r_wcol     <= r_col;
            o_tag      <= r_tag;
        end
    end

    // Shift the window one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < S; c++)
                for (int r = 0; r < S; r++) r_win[c][r] <= '0;
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= r_vld;
            if (r_vld) begin
                for (int c = 0; c + 1 < S; c++) r_win[c] <= r_win[c+1];
                for (int r = 0; r < L; r++) r_win[S-1][r] <= rd_col[r*PB +: PB];
                r_win[S-1][L] <= r_pix;
            end
        end
    end

    assign o_win = r_win;
endmodule

@@ design/median_filter_2d_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_2d_core
// Square-window median filter over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage: pixels enter on s_pix in raster order, one word per cycle. For each
// pixel whose (2h+1)x(2h+1) window lies inside the frame one result word
// leaves on m_res with the median, the centre column and row, and a flag on
// the frame's last result. Border pixels give no word.
// Configuration words on s_cfg (index 0 half, 1 width, 2 height) restart
// the frame; write them only while the block is idle.
// Throughput: one pixel per cycle while the output is not stalled. The
// pipeline runs line store read, window shift, window load, 25 sort stages
// of the transposition sort, then the output register.
// Reset clears counters and window registers; the line store holds garbage
// until a full set of rows has passed, and is not cleared.
// When the receiver stalls, the whole pipeline holds; the output register
// keeps its word and input ready drops until it is taken.
// ----------------------------------------------------------------------------
module median_filter_2d_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mf2d_pix_if.sink          s_pix,
    mf2d_res_if.source        m_res,
    mf2d_cfg_if.sink          s_cfg
);
    localparam int PW = mf2d_pkg::POS_W;
    localparam int DW = mf2d_pkg::DIM_W;

    logic [mf2d_pkg::HALF_W-1:0] r_half;
    logic [DW-1:0]               r_width;
    logic [DW-1:0]               r_height;
    logic [PW-1:0]               r_col;
    logic [PW-1:0]               r_row;
    logic [DW-1:0]               w_eff;
    logic [DW-1:0]               h_eff;
    logic [mf2d_pkg::HALF_W-1:0] h;
    logic [PW-1:0]               h2;
    logic                        adv;
    logic                        in_ok;
    mf2d_pkg::t_tag              n_tag;
    logic                        win_vld;
    mf2d_pkg::t_tag              win_tag;
    mf2d_pkg::t_win              win;
    logic                        srt_vld;
    mf2d_pkg::t_tag              srt_tag;
    logic [mf2d_pkg::PIXEL_BITS-1:0] srt_med;
    logic                        r_ovld;
    logic [PW:0]                 n_col;

    // Effective configuration
    assign h     = (r_half > mf2d_pkg::HALF_W'(mf2d_pkg::MAX_HALF))
                   ? mf2d_pkg::HALF_W'(mf2d_pkg::MAX_HALF) : r_half;
    assign w_eff = (r_width == '0) ? DW'(1)
                 : (r_width > DW'(mf2d_pkg::MAX_WIDTH)) ? DW'(mf2d_pkg::MAX_WIDTH) : r_width;
    assign h_eff = (r_height == '0) ? DW'(1)
                 : (r_height > DW'(mf2d_pkg::MAX_HEIGHT)) ? DW'(mf2d_pkg::MAX_HEIGHT) : r_height;
    assign h2    = PW'({h, 1'b0});

    // Whole pipeline advances unless the output word is stuck
    assign adv         = !r_ovld || m_res.ready;
    assign s_pix.ready = adv;
    assign in_ok       = s_pix.valid && adv;
    assign s_cfg.ready = 1'b1;

    always_comb begin
        n_tag.emit = (r_col >= h2) && (r_row >= h2);
        n_tag.col  = r_col - PW'(h);
        n_tag.row  = r_row - PW'(h);
        n_tag.last = ({1'b0, r_col} == w_eff - DW'(1)) && ({1'b0, r_row} == h_eff - DW'(1));
        n_col      = {1'b0, r_col} + (PW+1)'(1);
    end

    // Hold configuration; a half, width or height write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half   <= mf2d_pkg::HALF_W'(1);
            r_width  <= DW'(4096);
            r_height <= DW'(4096);
            r_col    <= '0;
            r_row    <= '0;
        end else if (s_cfg.valid) begin
            unique case (mf2d_pkg::t_reg_idx'(s_cfg.index))
                mf2d_pkg::t_REG_HALF:   r_half   <= s_cfg.data[mf2d_pkg::HALF_W-1:0];
                mf2d_pkg::t_REG_WIDTH:  r_width  <= s_cfg.data;
                mf2d_pkg::t_REG_HEIGHT: r_height <= s_cfg.data;
                default: ;
            endcase
            if (mf2d_pkg::t_reg_idx'(s_cfg.index) != mf2d_pkg::t_REG_NONE) begin
                r_col <= '0;
                r_row <= '0;
            end
        end else if (in_ok) begin
            if (n_col >= {1'b0, w_eff}) begin
                r_col <= '0;
                r_row <= ({1'b0, r_row} + DW'(1) >= h_eff) ? '0 : r_row + PW'(1);
            end else begin
                r_col <= n_col[PW-1:0];
            end
        end
    end

    mf2d_window u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (in_ok),
        .i_col   (r_col),
        .i_pixel (s_pix.pixel),
        .i_tag   (n_tag),
        .o_valid (win_vld),
        .o_tag   (win_tag),
        .o_win   (win)
    );

    mf2d_sort u_sort (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (win_vld && win_tag.emit),
        .i_tag    (win_tag),
        .i_half   (h),
        .i_win    (win),
        .o_valid  (srt_vld),
        .o_tag    (srt_tag),
        .o_median (srt_med)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (adv) begin
            r_ovld <= srt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            m_res.median        <= srt_med;
            m_res.out_col       <= srt_tag.col;
            m_res.out_row       <= srt_tag.row;
            m_res.last_of_frame <= srt_tag.last;
        end
    end

    assign m_res.valid = r_ovld;

    // Stalled result word must hold
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !m_res.ready |=> r_ovld && $stable(m_res.median))
        else $error("result dropped under stall");
    // No input taken while the output is stuck
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !m_res.ready |-> !s_pix.ready)
        else $error("input accepted during stall");
    // Column counter stays inside the frame
    a_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col} < w_eff || $past(s_cfg.valid))
        else $error("column count out of frame");
endmodule

@@ tb/mf2d_median_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_median_checker
// Watches the pixel, result and register channels of the median filter,
// predicts each result word from its own copy of the line stores, the
// window and the position counters, and compares every accepted result word
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module mf2d_median_checker
    import mf2d_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    mf2d_pix_if   pix,
    mf2d_res_if   res,
    mf2d_cfg_if   cfg,
    output int    o_fails,
    output int    o_pending
);

    typedef struct {
        logic [15:0] median;
        logic [11:0] col;
        logic [11:0] row;
        logic        last;
    } t_median_word;

    logic [15:0]      line_rows [LINES][MAX_WIDTH];
    logic [15:0]      win_cols  [SIDE_MAX][SIDE_MAX];
    logic [11:0]      col_pos;
    logic [11:0]      row_pos;
    logic [HALF_W-1:0] half_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    t_median_word     median_queue [$];

    // Advance the filter state by one pixel; return 1 with the word when the
    // window lies wholly inside the frame.
    function automatic bit window_median(input logic [15:0] px, output t_median_word wd);
        int          h, w, ht, c, r, side, n, j;
        logic [15:0] colv [SIDE_MAX];
        logic [15:0] vals [WIN_N];
        logic [15:0] v;
        bit          hit;
        h  = (half_reg > MAX_HALF) ? MAX_HALF : half_reg;
        w  = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        ht = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
        side = 2 * h + 1;
        c = col_pos;
        r = row_pos;
        if (c >= w) c = w - 1;
        if (r >= ht) r = ht - 1;
        // build the new column and shift the line stores up
        for (int k = 0; k < LINES; k++) colv[k] = line_rows[k][c];
        colv[LINES] = px;
        for (int k = 0; k + 1 < LINES; k++) line_rows[k][c] = line_rows[k+1][c];
        line_rows[LINES-1][c] = px;
        // shift the window by one column
        for (int i = 0; i + 1 < SIDE_MAX; i++) win_cols[i] = win_cols[i+1];
        win_cols[SIDE_MAX-1] = colv;
        hit = 0;
        wd = '{default: '0};
        if (c >= 2 * h && r >= 2 * h) begin
            n = 0;
            for (int ci = SIDE_MAX - side; ci < SIDE_MAX; ci++) begin
                for (int ri = SIDE_MAX - side; ri < SIDE_MAX; ri++) begin
                    v = win_cols[ci][ri];
                    j = n;
                    while (j > 0 && vals[j-1] > v) begin
                        vals[j] = vals[j-1];
                        j--;
                    end
                    vals[j] = v;
                    n++;
                end
            end
            wd.median = vals[n/2];
            wd.col    = 12'(c - h);
            wd.row    = 12'(r - h);
            wd.last   = (c == w - 1 && r == ht - 1);
            hit = 1;
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= ht) r = 0;
        end
        col_pos = 12'(c);
        row_pos = 12'(r);
        return hit;
    endfunction

    always @(posedge i_clk) begin
        t_median_word exp_w, new_w;
        if (!i_rst_n) begin
            half_reg   <= 2'd1;
            width_reg  <= 13'd4096;
            height_reg <= 13'd4096;
            col_pos    = '0;
            row_pos    = '0;
            for (int i = 0; i < SIDE_MAX; i++)
                for (int k = 0; k < SIDE_MAX; k++) win_cols[i][k] = '0;
            for (int k = 0; k < LINES; k++)
                for (int c = 0; c < MAX_WIDTH; c++) line_rows[k][c] = '0;
            median_queue.delete();
            o_fails <= 0;
        end else begin
            // compare a taken result word with the oldest prediction
            if (res.valid && res.ready) begin
                if (median_queue.size() == 0) begin
                    $display("%0t: unexpected result word median=%0d col=%0d row=%0d",
                             $time, res.median, res.out_col, res.out_row);
                    o_fails <= o_fails + 1;
                end else begin
                    exp_w = median_queue.pop_front();
                    if (res.median !== exp_w.median || res.out_col !== exp_w.col ||
                        res.out_row !== exp_w.row || res.last_of_frame !== exp_w.last) begin
                        $display("%0t: mismatch expected median=%0d col=%0d row=%0d last=%0b",
                                 $time, exp_w.median, exp_w.col, exp_w.row, exp_w.last);
                        $display("%0t:          actual   median=%0d col=%0d row=%0d last=%0b",
                                 $time, res.median, res.out_col, res.out_row,
                                 res.last_of_frame);
                        o_fails <= o_fails + 1;
                    end
                end
            end
            // predict from a taken pixel word
            if (pix.valid && pix.ready) begin
                if (window_median(pix.pixel, new_w)) median_queue.push_back(new_w);
            end
            // register writes restart the frame; an unknown index is dropped
            if (cfg.valid && cfg.ready) begin
                case (t_reg_idx'(cfg.index))
                    t_REG_HALF: begin
                        half_reg <= cfg.data[HALF_W-1:0];
                        col_pos = '0;
                        row_pos = '0;
                    end
                    t_REG_WIDTH: begin
                        width_reg <= cfg.data;
                        col_pos = '0;
                        row_pos = '0;
                    end
                    t_REG_HEIGHT: begin
                        height_reg <= cfg.data;
                        col_pos = '0;
                        row_pos = '0;
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= median_queue.size();
    end

endmodule

@@ tb/median_filter_2d_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_2d_core_test
// Drives frames through the median filter under random gaps and output
// stalls: a priming frame fills the line store columns in use, directed
// frames cover the window sizes and size clamps, then random small frames
// under random settings. The checker predicts and compares every word.
// ----------------------------------------------------------------------------
module median_filter_2d_core_test;
    import mf2d_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int RANDOM_PIXELS = 1350;
    localparam int PRIME_WIDTH  = 24;

    logic i_clk;
    logic i_rst_n;
    int   fails;
    int   pending;
    int   cycles;
    bit   calm;
    int   random_sent;

    mf2d_pix_if pix ();
    mf2d_res_if res ();
    mf2d_cfg_if cfg ();

    median_filter_2d_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_pix   (pix),
        .m_res   (res),
        .s_cfg   (cfg)
    );

    mf2d_median_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .pix       (pix),
        .res       (res),
        .cfg       (cfg),
        .o_fails   (fails),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // stall the result side in bursts
    initial begin
        res.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // pick a pixel: extremes, narrow ranges for ties, or full random
    function automatic logic [15:0] pick_pixel();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 3));
            3: return 16'($urandom_range(65532, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [15:0] p);
        if (!calm && $urandom_range(0, 3) == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.pixel <= p;
        do @(posedge i_clk); while (!pix.ready);
    endtask

    // hold until every predicted word is out and the pipeline is empty
    task automatic wait_idle();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [12:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [12:0] half, input logic [12:0] w,
                             input logic [12:0] ht);
        wait_idle();
        write_reg(t_REG_HALF, half);
        write_reg(t_REG_WIDTH, w);
        write_reg(t_REG_HEIGHT, ht);
    endtask

    task automatic send_pixels(input int count);
        for (int i = 0; i < count; i++) send_pixel(pick_pixel());
    endtask

    initial begin
        int h, w, ht, wc, hc, frames;
        calm = 0;
        cycles = 0;
        random_sent = 0;
        pix.valid <= 1'b0;
        pix.pixel <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= t_REG_HALF;
        cfg.data  <= '0;
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every line store row of the columns in use; a 4-row frame
        // with the widest window gives no word
        set_frame(2, 13'(PRIME_WIDTH), 4);
        send_pixels(4 * PRIME_WIDTH);

        // single-pixel frames: the window is the pixel itself; then a 3x3 frame
        set_frame(0, 1, 1);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h5555);
        send_pixel(16'hAAAA);
        set_frame(1, 3, 3);
        send_pixels(9);
        // half above the built maximum clamps
        set_frame(3, 5, 5);
        send_pixels(25);
        // zero width and height count as one
        set_frame(0, 0, 0);
        send_pixels(2);
        // frame too narrow for the window gives nothing
        set_frame(2, 4, 9);
        send_pixels(36);
        // unknown register index is dropped without restarting the frame
        set_frame(1, 6, 5);
        send_pixels(14);
        wait_idle();
        write_reg(t_REG_NONE, 13'h1FFF);
        send_pixels(16);

        // random settings over small frames
        while (random_sent < RANDOM_PIXELS) begin
            h  = $urandom_range(0, 3);
            w  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, PRIME_WIDTH);
            ht = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            set_frame(13'(h), 13'(w), 13'(ht));
            wc = (w == 0) ? 1 : w;
            hc = (ht == 0) ? 1 : ht;
            frames = $urandom_range(1, 3);
            send_pixels(frames * wc * hc);
            random_sent += frames * wc * hc;
        end

        // closing frames with no gaps and no stalls
        wait_idle();
        calm = 1;
        set_frame(1, 8, 6);
        send_pixels(2 * 48);

        wait_idle();
        if (fails == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
